// ----- sv/gradient_palette_rgb565_assert.svh -----
// Assertion macros shared by the gradient palette RTL.
`ifndef GRADIENT_PALETTE_RGB565_ASSERT_SVH
`define GRADIENT_PALETTE_RGB565_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/gpr_pkg.sv -----
// Shared constants and types for the gradient palette pipeline.
package gpr_pkg;

  // Field and datapath widths
  localparam int INDEX_W    = 8;
  localparam int COUNT_W    = 3;
  localparam int CHAN_W     = 8;
  localparam int CHAN_NUM   = 3;
  localparam int COLOR_W    = CHAN_W * CHAN_NUM;
  localparam int FRAC_W     = 8;
  localparam int SEG_W      = COUNT_W;
  localparam int POS_W      = INDEX_W + COUNT_W;
  localparam int DIFF_W     = CHAN_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int RGB565_W   = 16;
  localparam int DOUBLED_W  = 2 * RGB565_W;

  // Stop storage and saturation limit
  localparam int STOP_NUM   = 6;
  localparam int MAX_STOPS  = 6;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  // Register map indexes
  localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STOP_FIRST = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOP_LAST  = 3'd6;

  // Reset values
  localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;
  localparam logic [COLOR_W-1:0] STOP1_RESET = 24'hFFFFFF;

  typedef logic [COLOR_W-1:0] color_t;

  // Live configuration seen by the datapath
  typedef struct packed {
    logic [COUNT_W-1:0]       count;   // effective stop count, 1..MAX_STOPS
    color_t [STOP_NUM-1:0]    stops;
  } cfg_t;

  // Stage 1 result: segment pair and fraction
  typedef struct packed {
    logic [SEG_W-1:0]  seg;
    logic [SEG_W-1:0]  nxt;
    logic [FRAC_W-1:0] frac;
  } seg_t;

  // Stage 2 result: start color and signed channel deltas
  typedef struct packed {
    color_t                        base;
    logic [CHAN_NUM-1:0][DIFF_W-1:0] diff;
    logic [FRAC_W-1:0]             frac;
  } diff_t;

  // Stage 3 result: start color and per-channel offsets mod 256
  typedef struct packed {
    color_t                          base;
    logic [CHAN_NUM-1:0][CHAN_W-1:0] step;
  } step_t;

endpackage

// ----- sv/gpr_cfg.sv -----
// APB register file holding the stop count and the color stops.
module gpr_cfg
  import gpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [COUNT_W-1:0]    count_r;
  color_t [STOP_NUM-1:0] stops_r;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [SEG_W-1:0]      stop_sel;
  logic                  is_stop;
  logic                  wr_en;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite;
  assign reg_idx  = paddr[CFG_ADDR_W-1:2];
  assign stop_sel = SEG_W'(reg_idx - REG_STOP_FIRST);
  assign is_stop  = (reg_idx >= REG_STOP_FIRST) && (reg_idx <= REG_STOP_LAST);

  // Register writes; addresses past the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      // stop 1 starts white, the others black
      for (int i = 0; i < STOP_NUM; i++) begin
        stops_r[i] <= (i == 1) ? STOP1_RESET : '0;
      end
    end else if (wr_en) begin
      if (reg_idx == REG_STOP_COUNT) begin
        count_r <= pwdata[COUNT_W-1:0];
      end else if (is_stop) begin
        stops_r[stop_sel] <= pwdata[COLOR_W-1:0];
      end
    end
  end

  // Readback
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_STOP_COUNT) begin
      prdata = CFG_DATA_W'(count_r);
    end else if (is_stop) begin
      prdata = CFG_DATA_W'(stops_r[stop_sel]);
    end
  end

  // Effective count: zero acts as one stop, large values saturate
  always_comb begin
    cfg.stops = stops_r;
    priority if (count_r == '0) begin
      cfg.count = COUNT_W'(1);
    end else if (count_r > COUNT_W'(MAX_STOPS)) begin
      cfg.count = COUNT_W'(MAX_STOPS);
    end else begin
      cfg.count = count_r;
    end
  end

endmodule

// ----- sv/gpr_seg.sv -----
// Stage 1: scale the index by the stop count into segment and fraction.
module gpr_seg
  import gpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] count,
  input  logic               in_valid,
  input  logic [INDEX_W-1:0] in_palette_index,
  output logic               in_stall,
  output logic               s1_valid_r,
  output seg_t               s1_r,
  input  logic               dn_ready
);

  logic             ready;
  logic [POS_W-1:0] pos;
  logic [SEG_W-1:0] seg_raw;
  logic [SEG_W:0]   nxt_full;
  seg_t             s1_nxt;

  assign ready    = !s1_valid_r || dn_ready;
  assign in_stall = !ready;

  // pos = index * n; top bits pick the segment, low byte is the fraction
  always_comb begin
    pos         = POS_W'(in_palette_index) * POS_W'(count);
    seg_raw     = pos[POS_W-1:FRAC_W];
    s1_nxt.frac = pos[FRAC_W-1:0];
    s1_nxt.seg  = (seg_raw >= count) ? '0 : seg_raw;
    nxt_full    = {1'b0, s1_nxt.seg} + (SEG_W+1)'(1);
    // last segment wraps to stop 0
    s1_nxt.nxt  = (nxt_full >= {1'b0, count}) ? '0 : nxt_full[SEG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

// ----- sv/gpr_blend.sv -----
// Stages 2 and 3: fetch the stop pair, form deltas, scale by the fraction.
module gpr_blend
  import gpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  color_t [STOP_NUM-1:0] stops,
  input  logic                  up_valid,
  input  seg_t                  up,
  output logic                  up_ready,
  output logic                  s2_valid_r,
  output logic                  s3_valid_r,
  output step_t                 s3_r,
  input  logic                  dn_ready
);

  logic                s2_ready;
  logic                s3_ready;
  color_t              col_a;
  color_t              col_b;
  diff_t               s2_nxt;
  diff_t               s2_r;
  step_t               s3_nxt;
  logic signed [PROD_W-1:0] prod [CHAN_NUM];

  assign s3_ready = !s3_valid_r || dn_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign up_ready = s2_ready;

  // Stage 2: b - a per channel, 9-bit two's complement
  always_comb begin
    col_a       = stops[up.seg];
    col_b       = stops[up.nxt];
    s2_nxt.base = col_a;
    s2_nxt.frac = up.frac;
    for (int c = 0; c < CHAN_NUM; c++) begin
      s2_nxt.diff[c] = {1'b0, col_b[c*CHAN_W +: CHAN_W]}
                     - {1'b0, col_a[c*CHAN_W +: CHAN_W]};
    end
  end

  // Stage 3: (b - a) * f, arithmetic shift by 8 gives floor; keep low byte
  always_comb begin
    s3_nxt.base = s2_r.base;
    for (int c = 0; c < CHAN_NUM; c++) begin
      prod[c]        = $signed(s2_r.diff[c]) * $signed({1'b0, s2_r.frac});
      s3_nxt.step[c] = prod[c][FRAC_W +: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= up_valid;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && up_valid) begin
      s2_r <= s2_nxt;
    end
    if (s3_ready && s2_valid_r) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

// ----- sv/gpr_pack.sv -----
// Stage 4: final add, RGB565 packing with byte swap, output register.
module gpr_pack
  import gpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  step_t                up,
  output logic                 up_ready,
  output logic                 out_valid,
  output logic [RGB565_W-1:0]  out_color_swapped,
  output logic [DOUBLED_W-1:0] out_color_doubled,
  input  logic                 out_stall
);

  logic                            out_valid_r;
  logic [RGB565_W-1:0]             swapped_r;
  logic [RGB565_W-1:0]             swapped_nxt;
  logic [RGB565_W-1:0]             c565;
  logic [CHAN_NUM-1:0][CHAN_W-1:0] chan;

  assign up_ready = !out_valid_r || !out_stall;

  // a + step wraps mod 256; channel 2 is red, 1 green, 0 blue
  always_comb begin
    for (int c = 0; c < CHAN_NUM; c++) begin
      chan[c] = up.base[c*CHAN_W +: CHAN_W] + up.step[c];
    end
    c565        = {chan[2][7:3], chan[1][7:2], chan[0][7:3]};
    swapped_nxt = {c565[7:0], c565[15:8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      swapped_r <= swapped_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_color_swapped = swapped_r;
  assign out_color_doubled = {swapped_r, swapped_r};

endmodule

// ----- sv/gradient_palette_rgb565.sv -----
// Top level of the cyclic gradient palette lookup with RGB565 output.
//
//  channel  direction  handshake           payload
//  in_      input      in_valid/in_stall   in_palette_index[7:0]
//  out_     output     out_valid/out_stall out_color_swapped[15:0], out_color_doubled[31:0]
//  config   APB        psel/penable/pready paddr[4:0], pwdata/prdata[31:0]
//
// One index per clock while in_stall is low; four register stages (segment,
// delta, scale, pack) lie between an accepted index and its result. The 9x9
// signed multiply in stage 3 is the deepest path. rst_n is synchronous; it
// empties the pipeline and loads register defaults. A stall fills bubbles
// first; in_stall rises only when all stages are full.
module gradient_palette_rgb565
  import gpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [INDEX_W-1:0]    in_palette_index,
  output logic                  in_stall,
  output logic                  out_valid,
  output logic [RGB565_W-1:0]   out_color_swapped,
  output logic [DOUBLED_W-1:0]  out_color_doubled,
  input  logic                  out_stall,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  `include "gradient_palette_rgb565_assert.svh"

  cfg_t  cfg;
  logic  s1_valid;
  seg_t  s1;
  logic  s2_valid;
  logic  s3_valid;
  step_t s3;
  logic  blend_ready;
  logic  pack_ready;
  logic  pipe_full;
  logic  count_ok;

  // Configuration registers
  gpr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage 1
  gpr_seg u_seg (
    .clk              (clk),
    .rst_n            (rst_n),
    .count            (cfg.count),
    .in_valid         (in_valid),
    .in_palette_index (in_palette_index),
    .in_stall         (in_stall),
    .s1_valid_r       (s1_valid),
    .s1_r             (s1),
    .dn_ready         (blend_ready)
  );

  // Stages 2 and 3
  gpr_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .stops      (cfg.stops),
    .up_valid   (s1_valid),
    .up         (s1),
    .up_ready   (blend_ready),
    .s2_valid_r (s2_valid),
    .s3_valid_r (s3_valid),
    .s3_r       (s3),
    .dn_ready   (pack_ready)
  );

  // Stage 4 and output register
  gpr_pack u_pack (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (s3_valid),
    .up                (s3),
    .up_ready          (pack_ready),
    .out_valid         (out_valid),
    .out_color_swapped (out_color_swapped),
    .out_color_doubled (out_color_doubled),
    .out_stall         (out_stall)
  );

  // Checker helpers
  assign pipe_full = s1_valid && s2_valid && s3_valid && out_valid && out_stall;
  assign count_ok  = (cfg.count != '0) && (cfg.count <= COUNT_W'(MAX_STOPS));

  // Input backpressure only with every stage occupied and the output held
  `GPR_ASSERT_IMPL(a_stall_full, in_stall, pipe_full, "in_stall with a bubble in the pipeline")
  // A free output never stalls the input
  `GPR_ASSERT_IMPL(a_no_false_stall, !out_stall, !in_stall, "input stalled while output is free")
  // An accepted transaction lands in stage 1
  `GPR_ASSERT_NEXT(a_accept_lands, in_valid && !in_stall, s1_valid, "transaction lost at stage 1")
  // Effective stop count stays within 1..MAX_STOPS
  `GPR_ASSERT_IMPL(a_count_range, 1'b1, count_ok, "effective stop count out of range")

endmodule

// ----- sim/tb_gradient_palette_rgb565.sv -----
// Self-checking testbench for the cyclic gradient palette lookup with RGB565 output.
module tb_gradient_palette_rgb565;
  import gpr_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int PIPE_DEPTH    = 4;
  localparam int REG_UNMAPPED  = 7;
  localparam int MAX_REPORTS   = 20;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 100;

  typedef struct packed {
    logic [RGB565_W-1:0]  swapped;
    logic [DOUBLED_W-1:0] doubled;
  } palette_color_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic [INDEX_W-1:0]    in_palette_index;
  logic                  in_stall;
  logic                  out_valid;
  logic [RGB565_W-1:0]   out_color_swapped;
  logic [DOUBLED_W-1:0]  out_color_doubled;
  logic                  out_stall;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copy of the palette configuration
  logic [COUNT_W-1:0] cfg_stop_count;
  color_t             cfg_stops [STOP_NUM];

  palette_color_t expected_colors [$];
  int unsigned    error_count;

  gradient_palette_rgb565 u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_palette_index  (in_palette_index),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_color_swapped (out_color_swapped),
    .out_color_doubled (out_color_doubled),
    .out_stall         (out_stall),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("[gradient_palette_rgb565] ERROR");
    $finish;
  end

  // One channel: a + floor((b - a) * f / 256), wrapped to 8 bits
  function automatic logic [CHAN_W-1:0] blend_channel(logic [CHAN_W-1:0] a,
                                                      logic [CHAN_W-1:0] b,
                                                      int unsigned frac);
    int prod;
    prod = (int'(b) - int'(a)) * int'(frac);
    return CHAN_W'(int'(a) + (prod >>> 8));
  endfunction

  // Palette entry for one index under the current shadow configuration
  function automatic palette_color_t gradient_color(logic [INDEX_W-1:0] idx);
    int unsigned    n;
    int unsigned    pos;
    int unsigned    seg;
    int unsigned    nxt;
    int unsigned    frac;
    logic [7:0]     chan [3];
    logic [15:0]    rgb;
    logic [15:0]    sw;
    palette_color_t c;
    n = (cfg_stop_count == 0) ? 1 :
        (cfg_stop_count > MAX_STOPS) ? MAX_STOPS : cfg_stop_count;
    pos  = idx * n;
    seg  = pos >> 8;
    frac = pos & 255;
    if (seg >= n) seg = 0;
    nxt = (seg + 1 >= n) ? 0 : seg + 1;
    // chan[0] blue, chan[1] green, chan[2] red
    for (int k = 0; k < 3; k++)
      chan[k] = blend_channel(cfg_stops[seg][8*k +: 8], cfg_stops[nxt][8*k +: 8], frac);
    rgb = {chan[2][7:3], chan[1][7:2], chan[0][7:3]};
    sw  = {rgb[7:0], rgb[15:8]};
    c.swapped = sw;
    c.doubled = {sw, sw};
    return c;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  // Result checker
  always @(posedge clk) begin : check_results
    palette_color_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected transaction", 32'(out_color_swapped), 32'h0);
      end else begin
        exp_c = expected_colors.pop_front();
        if (out_color_swapped !== exp_c.swapped)
          report_mismatch("color_swapped", 32'(out_color_swapped), 32'(exp_c.swapped));
        if (out_color_doubled !== exp_c.doubled)
          report_mismatch("color_doubled", out_color_doubled, exp_c.doubled);
      end
    end
  end

  // Receiver stall pattern: none, sparse random, or long held runs
  int unsigned stall_mode;
  int unsigned mode_left;
  int unsigned hold_left;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        if (hold_left == 0) begin
          out_stall <= ~out_stall;
          hold_left <= $urandom_range(1, 12);
        end else begin
          hold_left <= hold_left - 1;
        end
      end
    endcase
  end

  // Present one index and wait for its transaction
  task automatic send_index(logic [INDEX_W-1:0] idx);
    @(negedge clk);
    in_valid         <= 1'b1;
    in_palette_index <= idx;
    do @(posedge clk); while (in_stall);
    expected_colors.push_back(gradient_color(idx));
  endtask

  task automatic idle_input(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid         <= 1'b0;
      in_palette_index <= INDEX_W'($urandom);
    end
  endtask

  // Drop valid and wait until every expected transaction has come out
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  // APB write: setup then access; shadow copy follows the same truncation rules
  task automatic write_reg(int unsigned reg_idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(reg_idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_idx == REG_STOP_COUNT)
      cfg_stop_count = value[COUNT_W-1:0];
    else if (reg_idx >= REG_STOP_FIRST && reg_idx <= REG_STOP_LAST)
      cfg_stops[reg_idx - REG_STOP_FIRST] = value[COLOR_W-1:0];
    @(negedge clk);
    // a mapped register reads back what it holds
    if (reg_idx == REG_STOP_COUNT) begin
      if (prdata !== CFG_DATA_W'(cfg_stop_count))
        report_mismatch("readback", prdata, CFG_DATA_W'(cfg_stop_count));
    end else if (reg_idx >= REG_STOP_FIRST && reg_idx <= REG_STOP_LAST) begin
      if (prdata !== CFG_DATA_W'(cfg_stops[reg_idx - REG_STOP_FIRST]))
        report_mismatch("readback", prdata,
                        CFG_DATA_W'(cfg_stops[reg_idx - REG_STOP_FIRST]));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_stops(color_t s0, color_t s1, color_t s2,
                             color_t s3, color_t s4, color_t s5);
    write_reg(REG_STOP_FIRST + 0, CFG_DATA_W'(s0));
    write_reg(REG_STOP_FIRST + 1, CFG_DATA_W'(s1));
    write_reg(REG_STOP_FIRST + 2, CFG_DATA_W'(s2));
    write_reg(REG_STOP_FIRST + 3, CFG_DATA_W'(s3));
    write_reg(REG_STOP_FIRST + 4, CFG_DATA_W'(s4));
    write_reg(REG_STOP_FIRST + 5, CFG_DATA_W'(s5));
  endtask

  // Reset palette: black to white and back, two stops
  task automatic test_reset_palette();
    send_index(8'd0);
    send_index(8'd1);
    send_index(8'd127);
    send_index(8'd128);
    send_index(8'd255);
    drain_pipeline();
  endtask

  // Stop count at one, at the maximum, zero and above the maximum
  task automatic test_stop_count_limits();
    write_stops(24'h102030, 24'hF0E0D0, 24'h00FF00, 24'hFF0000, 24'h0000FF, 24'h808080);
    write_reg(REG_STOP_COUNT, 32'd1);
    send_index(8'd0);
    send_index(8'd200);
    drain_pipeline();
    write_reg(REG_STOP_COUNT, CFG_DATA_W'(MAX_STOPS));
    send_index(8'd0);
    send_index(8'd43);
    send_index(8'd85);
    send_index(8'd255);
    drain_pipeline();
    // zero acts as a single stop
    write_reg(REG_STOP_COUNT, 32'd0);
    send_index(8'd77);
    drain_pipeline();
    // seven saturates to the maximum
    write_reg(REG_STOP_COUNT, 32'd7);
    send_index(8'd171);
    send_index(8'd255);
    drain_pipeline();
  endtask

  // Full-scale falling and mixed-sign deltas, wide writes, unmapped register
  task automatic test_channel_extremes();
    write_reg(REG_STOP_COUNT, 32'd2);
    write_stops(24'hFFFFFF, 24'h000000, 24'h0, 24'h0, 24'h0, 24'h0);
    send_index(8'd1);
    send_index(8'd129);
    send_index(8'd255);
    drain_pipeline();
    write_stops(24'hFF00FF, 24'h00FF00, 24'h0, 24'h0, 24'h0, 24'h0);
    send_index(8'd64);
    send_index(8'd200);
    drain_pipeline();
    // high bits above the register width are dropped
    write_reg(REG_STOP_FIRST, 32'hAB123456);
    write_reg(REG_STOP_COUNT, 32'hFFFFFFFA);
    send_index(8'd100);
    drain_pipeline();
    // write past the register map is ignored
    write_reg(REG_UNMAPPED, 32'hFFFFFFFF);
    send_index(8'd180);
    drain_pipeline();
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_stop_word();
    case ($urandom_range(0, 7))
      0:       return {$urandom_range(0, 255) << 24} | 32'h000000;
      1:       return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  // Random configurations with bursty index traffic
  task automatic test_random_palettes();
    int unsigned sent;
    int unsigned burst;
    int unsigned count_sel;
    logic [INDEX_W-1:0] idx;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       count_sel = 1;
        1:       count_sel = MAX_STOPS;
        2:       count_sel = 0;
        3:       count_sel = 7;
        default: count_sel = $urandom_range(1, MAX_STOPS);
      endcase
      write_reg(REG_STOP_COUNT, {$urandom_range(0, 255) << 8} | count_sel);
      for (int s = 0; s < STOP_NUM; s++)
        write_reg(REG_STOP_FIRST + s, random_stop_word());
      if ($urandom_range(0, 1) == 0)
        write_reg(REG_UNMAPPED, $urandom);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 16);
        for (int b = 0; b < burst; b++) begin
          case ($urandom_range(0, 9))
            0:       idx = 8'd0;
            1:       idx = 8'd255;
            default: idx = INDEX_W'($urandom);
          endcase
          send_index(idx);
          sent++;
        end
        if ($urandom_range(0, 3) != 0)
          idle_input($urandom_range(1, 8));
      end
      drain_pipeline();
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_palette_index = '0;
    out_stall        = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    stall_mode       = 0;
    mode_left        = 0;
    hold_left        = 0;
    error_count      = 0;
    cfg_stop_count   = COUNT_RESET;
    for (int s = 0; s < STOP_NUM; s++) cfg_stops[s] = '0;
    cfg_stops[1]     = STOP1_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_palette();
    test_stop_count_limits();
    test_channel_extremes();
    test_random_palettes();

    drain_pipeline();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (expected_colors.size() != 0)
      report_mismatch("missing transactions", expected_colors.size(), 32'h0);
    if (error_count == 0) begin
      $display("[gradient_palette_rgb565] OK");
    end else begin
      $display("[gradient_palette_rgb565] ERROR");
    end
    $finish;
  end

endmodule
